// ===== rtl/bpfr_pkg.sv =====
package bpfr_pkg;

  // Input transaction: one received byte or a status query
  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [10:0] position_mm;
    logic               ball_valid;
    logic               link_online;
    logic [1:0]         frame_event;
    logic [31:0]        byte_count;
    logic [31:0]        good_frame_count;
    logic [31:0]        bad_frame_count;
  } out_item_t;

  // Request codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Frame event codes
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_BAD      = 2'd2,
    EV_OVERFLOW = 2'd3
  } frame_event_t;

  // Parser phases
  typedef enum logic [3:0] {
    PH_B      = 4'd0,
    PH_A      = 4'd1,
    PH_L1     = 4'd2,
    PH_L2     = 4'd3,
    PH_COMMA1 = 4'd4,
    PH_SIGN   = 4'd5,
    PH_DIGIT1 = 4'd6,
    PH_DIGITS = 4'd7,
    PH_FLAG   = 4'd8,
    PH_END    = 4'd9,
    PH_GOOD   = 4'd10,
    PH_FAIL   = 4'd11
  } phase_t;

  // What the parser reports for one byte
  typedef struct packed {
    frame_event_t ev;
    logic         negative;
    logic [10:0]  magnitude;
    logic         flag;
  } parse_res_t;

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [14:0] MAG_LIMIT     = 15'd1000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

endpackage

// ===== rtl/bpfr_parser.sv =====
module bpfr_parser #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_en,
  input  logic [7:0]           rx_byte,
  output bpfr_pkg::parse_res_t res
);
  import bpfr_pkg::*;

  localparam int FILL_W = $clog2(BUFFER_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUFFER_BYTES - 1);

  logic [FILL_W-1:0] fill_count, fill_count_next;
  phase_t            parse_phase, parse_phase_next;
  logic              pending_negative, pending_negative_next;
  logic [10:0]       pending_magnitude, pending_magnitude_next;
  logic              pending_flag, pending_flag_next;
  frame_event_t      ev;

  logic        is_digit;
  logic [14:0] digit_acc;

  // Running magnitude times ten plus the new digit
  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit_acc = {1'b0, pending_magnitude, 3'b000} + {3'b000, pending_magnitude, 1'b0}
                   + {11'd0, rx_byte[3:0]};

  // Frame tracking and per-byte parse step
  always_comb begin
    fill_count_next        = fill_count;
    parse_phase_next       = parse_phase;
    pending_negative_next  = pending_negative;
    pending_magnitude_next = pending_magnitude;
    pending_flag_next      = pending_flag;
    ev                     = EV_NONE;
    if (byte_en) begin
      priority if (rx_byte == CH_DOLLAR) begin
        fill_count_next        = FILL_W'(1);
        parse_phase_next       = PH_B;
        pending_negative_next  = 1'b0;
        pending_magnitude_next = 11'd0;
        pending_flag_next      = 1'b0;
      end else if (fill_count == '0 || rx_byte == CH_CR) begin
        // outside a frame, or skipped
      end else if (rx_byte == CH_LF) begin
        ev = (parse_phase == PH_END || parse_phase == PH_GOOD) ? EV_GOOD : EV_BAD;
        fill_count_next  = '0;
        parse_phase_next = PH_B;
      end else if (fill_count < FILL_MAX) begin
        fill_count_next = fill_count + FILL_W'(1);
        unique case (parse_phase)
          PH_B:      parse_phase_next = (rx_byte == CH_B) ? PH_A : PH_FAIL;
          PH_A:      parse_phase_next = (rx_byte == CH_A) ? PH_L1 : PH_FAIL;
          PH_L1:     parse_phase_next = (rx_byte == CH_L) ? PH_L2 : PH_FAIL;
          PH_L2:     parse_phase_next = (rx_byte == CH_L) ? PH_COMMA1 : PH_FAIL;
          PH_COMMA1: parse_phase_next = (rx_byte == CH_COMMA) ? PH_SIGN : PH_FAIL;
          PH_SIGN, PH_DIGIT1, PH_DIGITS: begin
            if (is_digit) begin
              if (digit_acc > MAG_LIMIT) begin
                parse_phase_next = PH_FAIL;
              end else begin
                pending_magnitude_next = digit_acc[10:0];
                parse_phase_next       = PH_DIGITS;
              end
            end else if (parse_phase == PH_SIGN && rx_byte == CH_MINUS) begin
              pending_negative_next = 1'b1;
              parse_phase_next      = PH_DIGIT1;
            end else if (parse_phase == PH_SIGN && rx_byte == CH_PLUS) begin
              parse_phase_next = PH_DIGIT1;
            end else if (parse_phase == PH_DIGITS && rx_byte == CH_COMMA) begin
              parse_phase_next = PH_FLAG;
            end else begin
              parse_phase_next = PH_FAIL;
            end
          end
          PH_FLAG: begin
            if (rx_byte == CH_ZERO || rx_byte == CH_ONE) begin
              pending_flag_next = rx_byte[0];
              parse_phase_next  = PH_END;
            end else begin
              parse_phase_next = PH_FAIL;
            end
          end
          PH_END:  parse_phase_next = (rx_byte == CH_NUL) ? PH_GOOD : PH_FAIL;
          default: parse_phase_next = parse_phase;
        endcase
      end else begin
        // buffer full: drop the frame
        fill_count_next  = '0;
        parse_phase_next = PH_B;
        ev               = EV_OVERFLOW;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count        <= '0;
      parse_phase       <= PH_B;
      pending_negative  <= 1'b0;
      pending_magnitude <= 11'd0;
      pending_flag      <= 1'b0;
    end else begin
      fill_count        <= fill_count_next;
      parse_phase       <= parse_phase_next;
      pending_negative  <= pending_negative_next;
      pending_magnitude <= pending_magnitude_next;
      pending_flag      <= pending_flag_next;
    end
  end

  // Values of the frame that this byte closes
  always_comb begin
    res.ev        = ev;
    res.negative  = pending_negative;
    res.magnitude = pending_magnitude;
    res.flag      = pending_flag;
  end

endmodule

// ===== rtl/ball_position_frame_receiver.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------
// input    | in_valid, in_stall | in_item  (req_type, rx_byte, now_ms)
// output   | out_valid,out_stall| out_item (position, flags, event, counts)
// config   | cfg_we             | cfg_data (offline_timeout_ms)
//
// One transaction per cycle while in_stall is low; each result is registered in
// the output register, or in the skid register while the output is held by out_stall.
// Frame state, latches and counters update in the same cycle. The skid keeps input
// acceptance independent of out_stall; in_stall rises only when both hold a result.
// rst is synchronous; after it all control state is zero and the timeout is 2000 ms.
module ball_position_frame_receiver #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpfr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bpfr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import bpfr_pkg::*;

  logic       in_accept;
  logic       out_fire;
  logic       byte_en;
  parse_res_t pres;

  logic [15:0]        offline_timeout_ms;
  logic signed [10:0] latched_position, latched_position_next;
  logic               latched_valid, latched_valid_next;
  logic [31:0]        last_good_ms, last_good_ms_next;
  logic [31:0]        bytes_seen, bytes_seen_next;
  logic [31:0]        good_frames, good_frames_next;
  logic [31:0]        bad_frames, bad_frames_next;
  logic [31:0]        age_ms;
  out_item_t          result;

  logic      skid_valid;
  out_item_t skid_item;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign byte_en   = in_accept && (in_item.req_type == REQ_BYTE);

  bpfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_en),
    .rx_byte (in_item.rx_byte),
    .res     (pres)
  );

  // Latches and counters
  always_comb begin
    latched_position_next = latched_position;
    latched_valid_next    = latched_valid;
    last_good_ms_next     = last_good_ms;
    bytes_seen_next       = bytes_seen;
    good_frames_next      = good_frames;
    bad_frames_next       = bad_frames;
    if (byte_en) begin
      bytes_seen_next = bytes_seen + 32'd1;
    end
    unique case (pres.ev)
      EV_GOOD: begin
        latched_position_next = pres.negative ? -$signed(pres.magnitude)
                                              : $signed(pres.magnitude);
        latched_valid_next    = pres.flag;
        last_good_ms_next     = in_item.now_ms;
        good_frames_next      = good_frames + 32'd1;
      end
      EV_BAD, EV_OVERFLOW: bad_frames_next = bad_frames + 32'd1;
      default: ;
    endcase
  end

  // Result built from the updated state
  assign age_ms = in_item.now_ms - last_good_ms_next;

  always_comb begin
    result.position_mm      = latched_position_next;
    result.ball_valid       = latched_valid_next;
    result.link_online      = (good_frames_next != 32'd0) && (age_ms[31:16] == 16'd0)
                            && (age_ms[15:0] <= offline_timeout_ms);
    result.frame_event      = pres.ev;
    result.byte_count       = bytes_seen_next;
    result.good_frame_count = good_frames_next;
    result.bad_frame_count  = bad_frames_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offline_timeout_ms <= TIMEOUT_RESET;
      latched_position   <= '0;
      latched_valid      <= 1'b0;
      last_good_ms       <= '0;
      bytes_seen         <= '0;
      good_frames        <= '0;
      bad_frames         <= '0;
    end else begin
      if (cfg_we) begin
        offline_timeout_ms <= cfg_data;
      end
      if (in_accept) begin
        latched_position <= latched_position_next;
        latched_valid    <= latched_valid_next;
        last_good_ms     <= last_good_ms_next;
        bytes_seen       <= bytes_seen_next;
        good_frames      <= good_frames_next;
        bad_frames       <= bad_frames_next;
      end
    end
  end

  // Output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (in_accept) begin
        out_item <= result;
      end
    end else if (in_accept) begin
      skid_item <= result;
    end
  end

endmodule
